@@ hw/rtl/tpf_pkg.sv @@
// Shared types, constants and byte-pattern helpers for the test path token finder.
// Used by tpf_rule_eval and test_path_token_finder_top; depends on nothing else.
package tpf_pkg;

    localparam int unsigned LINE_MAX = 4096;
    localparam int unsigned POS_W    = $clog2(LINE_MAX + 1);
    localparam int unsigned BEG_W    = $clog2(LINE_MAX);

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SLASH = 8'h2f;

    localparam logic [1:0][63:0] PAT_INF = {64'(".spec."), 64'(".test.")};
    localparam logic [2:0][63:0] PAT_SFX = {64'("_test.rb"), 64'("_spec.rb"), 64'("_test.go")};
    localparam logic [63:0]      PAT_PY    = 64'(".py");
    localparam logic [63:0]      PAT_UTEST = 64'("_test");
    localparam logic [39:0]      PAT_TPFX  = 40'("test_");

    localparam logic [2:0] SEG_DONE = 3'd5;
    localparam logic [2:0] SEG_FAIL = 3'd7;

    typedef logic [7:0][7:0] win_t;

    typedef struct packed {
        logic             seen;
        logic             active;
        logic [2:0]       len;
        logic [7:0]       e0;
        logic [7:0]       e1;
        logic [7:0]       e2;
        logic [POS_W-1:0] fin;
    } infix_t;

    typedef struct packed {
        logic             seen;
        logic             decided;
        logic             ok;
        logic             base_ok;
        logic [POS_W-1:0] fin;
    } py_t;

    typedef struct packed {
        logic             seen;
        logic             decided;
        logic             ok;
        logic [POS_W-1:0] fin;
    } sfx_t;

    typedef struct packed {
        infix_t [1:0] inf;
        py_t          py;
        sfx_t [2:0]   sfx;
    } tracks_t;

    typedef struct packed {
        logic             hit;
        logic [POS_W-1:0] span;
    } hit_t;

    function automatic logic lower_char(input logic [7:0] c);
        return (c >= 8'h61) && (c <= 8'h7a);
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return lower_char(c) || ((c >= 8'h41) && (c <= 8'h5a)) ||
               ((c >= 8'h30) && (c <= 8'h39)) || (c == 8'h5f);
    endfunction

    // The newest byte sits at index 0, so the pattern's last character lines up with it.
    function automatic logic tail_is(input win_t w, input logic [63:0] pat,
                                     input int unsigned m);
        logic r;
        r = 1'b1;
        for (int unsigned j = 0; j < 8; j++)
        begin
            if ((j < m) && (w[j] != pat[8*j +: 8]))
            begin
                r = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic logic ext_known(input logic [2:0] len, input logic [7:0] e0,
                                       input logic [7:0] e1, input logic [7:0] e2);
        logic r;
        r = 1'b0;
        if (len == 3'd2)
        begin
            r = ({e0, e1} == 16'("ts")) || ({e0, e1} == 16'("js")) ||
                ({e0, e1} == 16'("py"));
        end
        else if (len == 3'd3)
        begin
            r = ({e0, e1, e2} == 24'("tsx")) || ({e0, e1, e2} == 24'("jsx")) ||
                ({e0, e1, e2} == 24'("mjs")) || ({e0, e1, e2} == 24'("cjs"));
        end
        return r;
    endfunction

    function automatic logic [7:0] prefix_char(input logic [2:0] p);
        logic [7:0] c;
        c = 8'h00;
        for (int unsigned k = 0; k < 5; k++)
        begin
            if (p == 3'(k))
            begin
                c = PAT_TPFX[8*(4-k) +: 8];
            end
        end
        return c;
    endfunction

endpackage

@@ hw/rtl/tpf_rule_eval.sv @@
// Rule priority evaluation for one token, from its per-pattern tracking state.
// Depends on tpf_pkg.
module tpf_rule_eval
(
    input  tpf_pkg::tracks_t tr,
    output tpf_pkg::hit_t    res
);

    logic [1:0] inf_ok;
    logic       py_ok;
    logic [2:0] sfx_ok;

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            inf_ok[i] = tr.inf[i].seen &&
                        tpf_pkg::ext_known(tr.inf[i].len, tr.inf[i].e0,
                                           tr.inf[i].e1, tr.inf[i].e2);
        end
        py_ok = tr.py.seen && tr.py.base_ok && (!tr.py.decided || tr.py.ok);
        for (int j = 0; j < 3; j++)
        begin
            sfx_ok[j] = tr.sfx[j].seen && (!tr.sfx[j].decided || tr.sfx[j].ok);
        end

        res.hit  = 1'b1;
        res.span = '0;
        if (inf_ok[0])
        begin
            res.span = tr.inf[0].fin + tpf_pkg::POS_W'(tr.inf[0].len);
        end
        else if (inf_ok[1])
        begin
            res.span = tr.inf[1].fin + tpf_pkg::POS_W'(tr.inf[1].len);
        end
        else if (py_ok)
        begin
            res.span = tr.py.fin;
        end
        else if (sfx_ok[0])
        begin
            res.span = tr.sfx[0].fin;
        end
        else if (sfx_ok[1])
        begin
            res.span = tr.sfx[1].fin;
        end
        else if (sfx_ok[2])
        begin
            res.span = tr.sfx[2].fin;
        end
        else
        begin
            res.hit = 1'b0;
        end
    end

endmodule

@@ hw/rtl/test_path_token_finder_top.sv @@
// Top level of the test path token finder: byte stream in, one result per line out.
// Depends on tpf_pkg and tpf_rule_eval.
//
// The input channel carries one byte of a line per transaction, with tlast on the
// final byte. Bytes are split into tokens at spaces and tabs, and each token is
// checked for a test-file path as it closes. The first matching token is kept.
// The output channel carries one transaction per line: found, the token's start
// offset, the length to the end of the recognized suffix, and an overflow flag for
// lines longer than LINE_MAX bytes (later bytes are ignored).
// A byte is taken in every cycle unless a result waits for m_tready. The result of a line
// appears on the output in the cycle after its last byte is accepted; all pattern
// tracking is updated per byte by shallow compares on an 8-byte window and never stalls.
// While a result waits for m_tready, s_tready still follows m_tready, so a byte
// can be accepted in the same cycle the waiting result leaves.
// Reset clears all line state and drops m_tvalid; the first byte afterwards
// starts a new line.
module test_path_token_finder_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] line_byte
    input  logic        s_tlast,   // line_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [0] found, [12:1] path_start, [25:13] path_length,
                                   // [26] line_overflow, [31:27] zero
);

    localparam int unsigned POS_W = tpf_pkg::POS_W;
    localparam int unsigned BEG_W = tpf_pkg::BEG_W;

    tpf_pkg::win_t    win_reg, win_next, win_post, win_sh;
    logic [POS_W-1:0] cnt_reg, cnt_next, cnt_post;
    tpf_pkg::tracks_t tr_reg, tr_next, tr_post, eval_in;
    logic [2:0]       seg_reg, seg_next, seg_post;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [BEG_W-1:0] tbeg_reg, tbeg_next, eval_beg;
    logic             in_tok_reg, in_tok_next;
    logic             lat_reg, lat_next;
    logic [BEG_W-1:0] mbeg_reg, mbeg_next;
    logic [POS_W-1:0] mspan_reg, mspan_next;
    logic             ovf_reg, ovf_next;
    logic             mvalid_reg, mvalid_next;
    logic             ofound_reg, ofound_next;
    logic [11:0]      ostart_reg, ostart_next;
    logic [12:0]      olen_reg, olen_next;
    logic             oovf_reg, oovf_next;

    tpf_pkg::hit_t    res;
    logic [7:0]       b;
    logic             acc, live, blank_byte, content, closing_sp, eval_tok, latch;

    tpf_rule_eval u_eval
    (
        .tr  (eval_in),
        .res (res)
    );

    assign s_tready = !mvalid_reg || m_tready;
    assign acc      = s_tvalid && s_tready;
    assign b        = s_tdata;
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {5'd0, oovf_reg, olen_reg, ostart_reg, ofound_reg};
    assign latch    = acc && (closing_sp || s_tlast) && eval_tok && !lat_reg && res.hit;

    always_comb
    begin
        live       = pos_reg < POS_W'(tpf_pkg::LINE_MAX);
        blank_byte = (b == tpf_pkg::CH_SPACE) || (b == tpf_pkg::CH_TAB);
        content    = live && !blank_byte;
        closing_sp = live && blank_byte;

        win_post = {win_reg[6:0], b};
        win_sh   = win_post >> 24;
        cnt_post = cnt_reg + POS_W'(1);
        tr_post  = tr_reg;
        seg_post = seg_reg;

        for (int i = 0; i < 2; i++)
        begin
            if (tr_reg.inf[i].active)
            begin
                if (tpf_pkg::lower_char(b))
                begin
                    case (tr_reg.inf[i].len)
                        3'd0:    tr_post.inf[i].e0 = b;
                        3'd1:    tr_post.inf[i].e1 = b;
                        3'd2:    tr_post.inf[i].e2 = b;
                        default: tr_post.inf[i].e2 = tr_reg.inf[i].e2;
                    endcase
                    if (tr_reg.inf[i].len < 3'd4)
                    begin
                        tr_post.inf[i].len = tr_reg.inf[i].len + 3'd1;
                    end
                end
                else
                begin
                    tr_post.inf[i].active = 1'b0;
                end
            end
            else if (!tr_reg.inf[i].seen && (cnt_post >= POS_W'(6)) &&
                     tpf_pkg::tail_is(win_post, tpf_pkg::PAT_INF[i], 6))
            begin
                tr_post.inf[i].seen   = 1'b1;
                tr_post.inf[i].active = 1'b1;
                tr_post.inf[i].len    = 3'd0;
                tr_post.inf[i].fin    = cnt_post;
            end
        end

        if (tr_reg.py.seen && !tr_reg.py.decided)
        begin
            tr_post.py.decided = 1'b1;
            tr_post.py.ok      = !tpf_pkg::is_word(b);
        end
        else if (!tr_reg.py.seen && (cnt_post >= POS_W'(3)) &&
                 tpf_pkg::tail_is(win_post, tpf_pkg::PAT_PY, 3))
        begin
            tr_post.py.seen    = 1'b1;
            tr_post.py.fin     = cnt_post;
            tr_post.py.base_ok = (seg_reg == tpf_pkg::SEG_DONE) ||
                                 ((cnt_post >= POS_W'(8)) &&
                                  tpf_pkg::tail_is(win_sh, tpf_pkg::PAT_UTEST, 5));
        end

        for (int j = 0; j < 3; j++)
        begin
            if (tr_reg.sfx[j].seen && !tr_reg.sfx[j].decided)
            begin
                tr_post.sfx[j].decided = 1'b1;
                tr_post.sfx[j].ok      = !tpf_pkg::is_word(b);
            end
            else if (!tr_reg.sfx[j].seen && (cnt_post >= POS_W'(8)) &&
                     tpf_pkg::tail_is(win_post, tpf_pkg::PAT_SFX[j], 8))
            begin
                tr_post.sfx[j].seen = 1'b1;
                tr_post.sfx[j].fin  = cnt_post;
            end
        end

        if (b == tpf_pkg::CH_SLASH)
        begin
            seg_post = 3'd0;
        end
        else if (seg_reg < tpf_pkg::SEG_DONE)
        begin
            seg_post = (b == tpf_pkg::prefix_char(seg_reg)) ? seg_reg + 3'd1
                                                             : tpf_pkg::SEG_FAIL;
        end

        eval_in  = content ? tr_post : tr_reg;
        eval_tok = content || in_tok_reg;
        eval_beg = (content && !in_tok_reg) ? pos_reg[BEG_W-1:0] : tbeg_reg;
    end

    always_comb
    begin
        win_next    = win_reg;
        cnt_next    = cnt_reg;
        tr_next     = tr_reg;
        seg_next    = seg_reg;
        pos_next    = pos_reg;
        tbeg_next   = tbeg_reg;
        in_tok_next = in_tok_reg;
        lat_next    = lat_reg;
        mbeg_next   = mbeg_reg;
        mspan_next  = mspan_reg;
        ovf_next    = ovf_reg;
        ofound_next = ofound_reg;
        ostart_next = ostart_reg;
        olen_next   = olen_reg;
        oovf_next   = oovf_reg;
        mvalid_next = mvalid_reg && !m_tready;

        if (acc)
        begin
            if (!live)
            begin
                ovf_next = 1'b1;
            end
            if (content)
            begin
                win_next    = win_post;
                cnt_next    = cnt_post;
                tr_next     = tr_post;
                seg_next    = seg_post;
                in_tok_next = 1'b1;
                tbeg_next   = eval_beg;
                pos_next    = pos_reg + POS_W'(1);
            end
            if (closing_sp)
            begin
                win_next    = '0;
                cnt_next    = '0;
                tr_next     = '0;
                seg_next    = '0;
                in_tok_next = 1'b0;
                pos_next    = pos_reg + POS_W'(1);
            end
            if (latch)
            begin
                lat_next   = 1'b1;
                mbeg_next  = eval_beg;
                mspan_next = res.span;
            end
            if (s_tlast)
            begin
                mvalid_next = 1'b1;
                ofound_next = lat_next;
                ostart_next = lat_next ? 12'(mbeg_next) : 12'd0;
                olen_next   = lat_next ? 13'(mspan_next) : 13'd0;
                oovf_next   = ovf_next;
                win_next    = '0;
                cnt_next    = '0;
                tr_next     = '0;
                seg_next    = '0;
                pos_next    = '0;
                tbeg_next   = '0;
                in_tok_next = 1'b0;
                lat_next    = 1'b0;
                mbeg_next   = '0;
                mspan_next  = '0;
                ovf_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg    <= '0;
            cnt_reg    <= '0;
            tr_reg     <= '0;
            seg_reg    <= '0;
            pos_reg    <= '0;
            tbeg_reg   <= '0;
            in_tok_reg <= 1'b0;
            lat_reg    <= 1'b0;
            mbeg_reg   <= '0;
            mspan_reg  <= '0;
            ovf_reg    <= 1'b0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            win_reg    <= win_next;
            cnt_reg    <= cnt_next;
            tr_reg     <= tr_next;
            seg_reg    <= seg_next;
            pos_reg    <= pos_next;
            tbeg_reg   <= tbeg_next;
            in_tok_reg <= in_tok_next;
            lat_reg    <= lat_next;
            mbeg_reg   <= mbeg_next;
            mspan_reg  <= mspan_next;
            ovf_reg    <= ovf_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ofound_reg <= ofound_next;
        ostart_reg <= ostart_next;
        olen_reg   <= olen_next;
        oovf_reg   <= oovf_next;
    end

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(tpf_pkg::LINE_MAX))
        else $error("byte position beyond line limit");

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> m_tvalid)
        else $error("line end did not produce a result transaction");

    a_nofound_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[25:1] == 25'd0))
        else $error("positions nonzero without a match");

    a_found_len: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[0]) |-> (m_tdata[25:13] >= 13'd3))
        else $error("match shorter than any suffix");

    a_token_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_tok_reg |-> (cnt_reg == '0))
        else $error("token count held with no open token");

endmodule

@@ sim/test_path_token_finder_top_tb.sv @@
// Self-checking testbench for test_path_token_finder_top: streams lines of bytes,
// predicts the per-line result in a behavioral model and checks each output transaction.
// Depends on tpf_pkg and the RTL of test_path_token_finder_top.
module test_path_token_finder_top_tb;

    typedef struct {
        logic [7:0] line_byte;
        logic       line_end;
    } line_item_t;

    typedef struct {
        logic        found;
        logic [11:0] path_start;
        logic [12:0] path_length;
        logic        line_overflow;
    } line_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;

    line_item_t   pending_bytes[$];
    line_result_t expected_results[$];
    int           error_count;
    int           cycle_count;
    bit           hold_sender;
    int           long_hold;
    int           burst_left;
    int           gap_left;

    byte unsigned tok_buf[$];
    int           line_pos;
    int           tok_begin;
    bit           tok_open;
    bit           hit_latched;
    int           hit_begin;
    int           hit_span;
    bit           line_over;

    test_path_token_finder_top uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic bit lower_byte(byte unsigned c);
        return c >= "a" && c <= "z";
    endfunction

    function automatic bit word_byte(byte unsigned c);
        return lower_byte(c) || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9") || c == "_";
    endfunction

    function automatic int find_first(string pat);
        int n;
        bit ok;
        n = pat.len();
        for (int i = 0; i + n <= tok_buf.size(); i++)
        begin
            ok = 1;
            for (int j = 0; j < n; j++)
            begin
                if (tok_buf[i + j] != pat[j])
                begin
                    ok = 0;
                end
            end
            if (ok)
            begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic bit span_is(int at, string pat);
        if (at < 0 || at + pat.len() > tok_buf.size())
        begin
            return 0;
        end
        for (int j = 0; j < pat.len(); j++)
        begin
            if (tok_buf[at + j] != pat[j])
            begin
                return 0;
            end
        end
        return 1;
    endfunction

    function automatic bit boundary_at(int e);
        return e == tok_buf.size() || !word_byte(tok_buf[e]);
    endfunction

    function automatic bit test_path_end(output int fin);
        string infixes[2];
        string suffixes[3];
        string run;
        int    at;
        int    e;
        int    base;
        infixes = '{".test.", ".spec."};
        suffixes = '{"_test.go", "_spec.rb", "_test.rb"};
        foreach (infixes[i])
        begin
            at = find_first(infixes[i]);
            if (at >= 0)
            begin
                e = at + 6;
                run = "";
                while (e < tok_buf.size() && lower_byte(tok_buf[e]))
                begin
                    run = {run, string'(tok_buf[e])};
                    e++;
                end
                if (run inside {"ts", "tsx", "js", "jsx", "mjs", "cjs", "py"})
                begin
                    fin = e;
                    return 1;
                end
            end
        end
        at = find_first(".py");
        if (at >= 0 && boundary_at(at + 3))
        begin
            base = 0;
            for (int j = at; j > 0; j--)
            begin
                if (tok_buf[j - 1] == "/")
                begin
                    base = j;
                    break;
                end
            end
            if (at - base >= 5 && (span_is(base, "test_") || span_is(at - 5, "_test")))
            begin
                fin = at + 3;
                return 1;
            end
        end
        foreach (suffixes[i])
        begin
            at = find_first(suffixes[i]);
            if (at >= 0 && boundary_at(at + 8))
            begin
                fin = at + 8;
                return 1;
            end
        end
        return 0;
    endfunction

    function automatic void close_open_token();
        int fin;
        if (tok_open && !hit_latched && test_path_end(fin))
        begin
            hit_latched = 1;
            hit_begin = tok_begin;
            hit_span = fin;
        end
        tok_open = 0;
        tok_buf.delete();
    endfunction

    function automatic void predict_line_byte(line_item_t it);
        line_result_t r;
        if (line_pos < tpf_pkg::LINE_MAX)
        begin
            if (it.line_byte == tpf_pkg::CH_SPACE || it.line_byte == tpf_pkg::CH_TAB)
            begin
                close_open_token();
            end
            else
            begin
                if (!tok_open)
                begin
                    tok_open = 1;
                    tok_begin = line_pos;
                end
                tok_buf.push_back(it.line_byte);
            end
            line_pos++;
        end
        else
        begin
            line_over = 1;
        end
        if (it.line_end)
        begin
            close_open_token();
            r.found = hit_latched;
            r.path_start = hit_latched ? 12'(hit_begin) : 12'd0;
            r.path_length = hit_latched ? 13'(hit_span) : 13'd0;
            r.line_overflow = line_over;
            expected_results.push_back(r);
            line_pos = 0;
            tok_begin = 0;
            hit_latched = 0;
            hit_begin = 0;
            hit_span = 0;
            line_over = 0;
        end
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    task automatic queue_line(string s);
        line_item_t it;
        for (int i = 0; i < s.len(); i++)
        begin
            it.line_byte = s[i];
            it.line_end = (i == s.len() - 1);
            pending_bytes.push_back(it);
        end
    endtask

    function automatic string random_token();
        string stems[6];
        string exts[10];
        string s;
        int    k;
        stems = '{"src/app", "test_util", "pkg/foo_test", "a/b/test_x", "lib/cart", "x"};
        exts = '{".test.ts", ".spec.jsx", ".test.mjs", ".spec.py", ".py", "_test.go",
                 "_spec.rb", "_test.rb", ".test.tsxx", ".pyc"};
        k = $urandom_range(0, 9);
        if (k < 6)
        begin
            s = {stems[$urandom_range(0, 5)], exts[$urandom_range(0, 9)]};
            if ($urandom_range(0, 2) == 0)
            begin
                s = {s, string'(byte'($urandom_range(33, 126)))};
            end
        end
        else
        begin
            s = "";
            repeat ($urandom_range(1, 8))
            begin
                s = {s, string'(byte'($urandom_range(1, 255)))};
            end
        end
        return s;
    endfunction

    task automatic queue_random_line();
        string s;
        int    nt;
        s = "";
        nt = $urandom_range(1, 4);
        for (int t = 0; t < nt; t++)
        begin
            s = {s, random_token(), ($urandom_range(0, 1) ? " " : "\t")};
        end
        if ($urandom_range(0, 1))
        begin
            s = s.substr(0, s.len() - 2);
        end
        queue_line(s);
    endtask

    task automatic queue_long_line();
        line_item_t it;
        int         n;
        n = tpf_pkg::LINE_MAX - 2 + $urandom_range(0, 22);
        for (int i = 0; i < n; i++)
        begin
            it.line_byte = (i % 37 == 0) ? tpf_pkg::CH_SPACE : 8'($urandom_range(0, 255));
            it.line_end = (i == n - 1);
            pending_bytes.push_back(it);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= 8'd0;
            s_tlast <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else
        begin
            if (!s_tvalid || s_tready)
            begin
                if (s_tvalid && s_tready)
                begin
                    predict_line_byte('{s_tdata, s_tlast});
                end
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_bytes.size() > 0 && !hold_sender)
                begin
                    line_item_t it;
                    it = pending_bytes.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= it.line_byte;
                    s_tlast <= it.line_end;
                    if (burst_left == 0)
                    begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (long_hold > 0)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= (cycle_count % 64 < 32) ? 1'b1 : ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_hold <= 0;
        end
        else if (long_hold > 0)
        begin
            long_hold <= long_hold - 1;
        end
        else if (cycle_count == 3000)
        begin
            long_hold <= 400;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected result", 1, 0);
            end
            else
            begin
                line_result_t w;
                w = expected_results.pop_front();
                if (m_tdata[0] !== w.found)
                    report_mismatch("found", m_tdata[0], w.found);
                if (m_tdata[12:1] !== w.path_start)
                    report_mismatch("path_start", m_tdata[12:1], w.path_start);
                if (m_tdata[25:13] !== w.path_length)
                    report_mismatch("path_length", m_tdata[25:13], w.path_length);
                if (m_tdata[26] !== w.line_overflow)
                    report_mismatch("line_overflow", m_tdata[26], w.line_overflow);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000)
        begin
            $display("timeout");
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        error_count = 0;
        cycle_count = 0;
        hold_sender = 0;
        line_pos = 0;
        tok_begin = 0;
        tok_open = 0;
        hit_latched = 0;
        hit_begin = 0;
        hit_span = 0;
        line_over = 0;
        queue_line("x");
        queue_line(" ");
        queue_line("run src/a.test.ts now");
        queue_line("b.spec.cjs\tc.test.py");
        queue_line("a.test.tsxq c.spec.js");
        queue_line("dir/test_foo.py");
        queue_line("dir/foo_test.py:12");
        queue_line("foo_test.pyc test_a.py");
        queue_line("pkg/x_test.go y_spec.rb z_test.rb");
        queue_line("x_test.gox a_spec.rb,");
        queue_line({"\t", string'(byte'(8'hff)), " ", string'(byte'(8'h01))});
        queue_line("no match here");
        queue_long_line();
        queue_line("after/test_ok.py");
        repeat (6) @(posedge clk);
        rst_n = 1'b1;
        while (pending_bytes.size() > 0)
            @(posedge clk);
        hold_sender = 1;
        while (expected_results.size() > 0 || s_tvalid)
            @(posedge clk);
        hold_sender = 0;
        while (pending_bytes.size() + 100 < 2000)
            queue_random_line();
        while (pending_bytes.size() > 0 || s_tvalid)
            @(posedge clk);
        while (expected_results.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
